/* hdl/mss_pkg.sv */
// Shared types and constants for the motion slew smoother.
// Beat structs, direction and motor mode codes, register map and fixed-point limits.
// No dependencies.
package mss_pkg;

    localparam int unsigned SPEED_W  = 15;
    localparam int unsigned ANGLE_W  = 17;
    localparam int unsigned PULSE_W  = 12;
    localparam int unsigned PADDR_W  = 4;

    localparam logic [SPEED_W-1:0] SPEED_MAX_Q8 = 15'd25600;
    localparam logic [SPEED_W-1:0] ONE_Q8       = 15'd256;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q8 = 17'd69120;
    localparam logic [6:0]         SPEED_PCT_MAX = 7'd100;
    localparam logic [8:0]         ANGLE_DEG_MAX = 9'd270;
    localparam logic [8:0]         ALPHA_FULL    = 9'd256;
    localparam logic [PULSE_W-1:0] PULSE_BASE    = 12'd500;
    // floor(u * 2000 / 69120) == (u * PULSE_RECIP) >> PULSE_SHIFT for every u <= 69120.
    localparam logic [25:0]        PULSE_RECIP   = 26'd62137850;
    localparam int unsigned        PULSE_SHIFT   = 31;

    localparam logic [14:0] MOTOR_SLEW_RESET = 15'd1280;
    localparam logic [16:0] ANGLE_SLEW_RESET = 17'd512;
    localparam logic [8:0]  ALPHA_RESET      = 9'd64;

    typedef enum logic [1:0] {
        REG_MOTOR_SLEW = 2'd0,
        REG_ANGLE_SLEW = 2'd1,
        REG_ALPHA      = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        DIR_STOP     = 3'd0,
        DIR_FORWARD  = 3'd1,
        DIR_BACKWARD = 3'd2,
        DIR_LEFT     = 3'd3,
        DIR_RIGHT    = 3'd4
    } t_dir;

    typedef enum logic [1:0] {
        MODE_STOP     = 2'd0,
        MODE_FORWARD  = 2'd1,
        MODE_BACKWARD = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0] target_direction;
        logic [6:0] target_speed;
        logic [8:0] target_shoulder_left;
        logic [8:0] target_shoulder_right;
        logic [8:0] target_elbow_left;
        logic [8:0] target_elbow_right;
        logic       drive_halt;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         motor_one_mode;
        logic [1:0]         motor_two_mode;
        logic [6:0]         motor_duty;
        logic [PULSE_W-1:0] shoulder_left_pulse;
        logic [PULSE_W-1:0] shoulder_right_pulse;
        logic [PULSE_W-1:0] elbow_left_pulse;
        logic [PULSE_W-1:0] elbow_right_pulse;
    } t_out_beat;

endpackage

/* hdl/mss_motor.sv */
// Drive state of the motion slew smoother: current direction and slew-limited speed.
// Depends on mss_pkg.
module mss_motor
    import mss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [2:0]         i_dir,
    input  logic [6:0]         i_speed,
    input  logic               i_estop,
    input  logic [SPEED_W-1:0] i_slew_step,
    output logic [2:0]         o_dir,
    output logic [SPEED_W-1:0] o_speed
);

    logic [2:0]         r_dir;
    logic [SPEED_W-1:0] r_speed;
    logic [2:0]         n_dir;
    logic [SPEED_W-1:0] n_speed;

    logic [2:0]         w_tdir;
    logic [6:0]         w_tspd;
    logic [SPEED_W-1:0] w_stgt;
    logic [SPEED_W-1:0] w_down;
    logic [SPEED_W-1:0] w_toward;

    always_comb begin
        w_tdir = (i_dir > DIR_RIGHT) ? DIR_STOP : i_dir;
        w_tspd = (i_speed > SPEED_PCT_MAX) ? SPEED_PCT_MAX : i_speed;
        w_stgt = (w_tdir == DIR_STOP) ? '0 : {w_tspd, 8'd0};

        // Ramp toward zero ahead of a direction change.
        if (i_slew_step == '0 || r_speed <= i_slew_step) begin
            w_down = '0;
        end else begin
            w_down = r_speed - i_slew_step;
        end

        if (i_slew_step == '0) begin
            w_toward = w_stgt;
        end else if (w_stgt > r_speed) begin
            w_toward = ((w_stgt - r_speed) > i_slew_step) ? r_speed + i_slew_step : w_stgt;
        end else begin
            w_toward = ((r_speed - w_stgt) > i_slew_step) ? r_speed - i_slew_step : w_stgt;
        end

        n_dir   = r_dir;
        n_speed = r_speed;
        if (i_estop) begin
            n_dir   = DIR_STOP;
            n_speed = '0;
        end else if (w_tdir != r_dir && r_speed > ONE_Q8) begin
            if (w_down <= ONE_Q8) begin
                n_dir   = w_tdir;
                n_speed = '0;
            end else begin
                n_speed = w_down;
            end
        end else begin
            n_dir   = w_tdir;
            n_speed = w_toward;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_STOP;
            r_speed <= '0;
        end else if (i_en) begin
            r_dir   <= n_dir;
            r_speed <= n_speed;
        end
    end

    assign o_dir   = r_dir;
    assign o_speed = r_speed;

endmodule

/* hdl/mss_joint.sv */
// One joint channel: slew limit toward the target angle, then a floored alpha filter.
// Depends on mss_pkg.
module mss_joint
    import mss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [ANGLE_W-1:0] i_reset_angle,
    input  logic [8:0]         i_target,
    input  logic [ANGLE_W-1:0] i_slew_step,
    input  logic [8:0]         i_alpha,
    output logic [ANGLE_W-1:0] o_angle
);

    logic [ANGLE_W-1:0]        r_angle;
    logic [ANGLE_W-1:0]        n_angle;

    logic [8:0]                w_tdeg;
    logic [ANGLE_W-1:0]        w_tgt;
    logic signed [ANGLE_W:0]   w_diff;
    logic signed [ANGLE_W+1:0] w_step;
    logic [ANGLE_W:0]          w_sum;
    logic [ANGLE_W-1:0]        w_lim;
    logic signed [ANGLE_W:0]   w_delta;
    logic signed [27:0]        w_prod;
    logic signed [19:0]        w_new;

    always_comb begin
        w_tdeg = (i_target > ANGLE_DEG_MAX) ? ANGLE_DEG_MAX : i_target;
        w_tgt  = {w_tdeg, 8'd0};
        w_diff = $signed({1'b0, w_tgt}) - $signed({1'b0, r_angle});
        w_step = $signed({2'b00, i_slew_step});
        w_sum  = {1'b0, r_angle} + {1'b0, i_slew_step};

        if (i_slew_step == '0) begin
            w_lim = w_tgt;
        end else if ($signed({w_diff[ANGLE_W], w_diff}) > w_step) begin
            w_lim = w_sum[ANGLE_W-1:0];
        end else if ($signed({w_diff[ANGLE_W], w_diff}) < -w_step) begin
            w_lim = r_angle - i_slew_step;
        end else begin
            w_lim = w_tgt;
        end

        // An arithmetic shift of the signed product floors toward minus infinity.
        w_delta = $signed({1'b0, w_lim}) - $signed({1'b0, r_angle});
        w_prod  = $signed({1'b0, i_alpha}) * w_delta;
        w_new   = $signed({3'b000, r_angle}) + 20'(w_prod >>> 8);
        n_angle = w_new[ANGLE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= i_reset_angle;
        end else if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

/* hdl/motion_slew_smoother_top.sv */
// Top level of the motion slew smoother: handshake pipeline, register port and outputs.
// Depends on mss_pkg, mss_motor and mss_joint.

// Each accepted beat is one control tick and yields exactly one result beat. The block
// takes a new beat every cycle unless i_out_stall has backed the pipeline up; each beat
// fills the input register, then updates the state, then has its servo pulse multiply
// registered into the output register, and i_out_stall holds the pipeline back without
// losing beats. The drive and joint state registers are the only loop: each tick
// reads the state the previous tick left.
// Configuration registers sit at byte addresses 0 (motor slew step), 4 (angle slew step)
// and 8 (filter alpha); write them only while no beat is in flight.
module motion_slew_smoother_top
    import mss_pkg::*;
#(
    parameter int unsigned DEFAULT_ANGLE = 90
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned DEF_DEG = (DEFAULT_ANGLE > 270) ? 270 : DEFAULT_ANGLE;
    localparam logic [ANGLE_W-1:0] RESET_ANGLE = ANGLE_W'(DEF_DEG * 256);

    logic [SPEED_W-1:0] r_motor_slew;
    logic [ANGLE_W-1:0] r_angle_slew;
    logic [8:0]         r_alpha;

    logic               r_in_valid;
    t_in_beat           r_in;
    logic               r_mid_valid;
    logic               r_out_valid;
    t_out_beat          r_out;
    t_out_beat          n_out;

    logic               w_en_out;
    logic               w_en_mid;
    logic               w_fire;
    logic               w_cfg_wr;
    logic [8:0]         w_alpha;

    logic [2:0]         w_dir;
    logic [SPEED_W-1:0] w_speed;
    logic [ANGLE_W-1:0] w_angle [4];
    logic [8:0]         w_target [4];
    logic [42:0]        w_pulse_prod [4];
    logic [PULSE_W-1:0] w_pulse [4];
    logic [SPEED_W-1:0] w_duty_sum;

    // Register port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_slew <= MOTOR_SLEW_RESET;
            r_angle_slew <= ANGLE_SLEW_RESET;
            r_alpha      <= ALPHA_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MOTOR_SLEW: r_motor_slew <= pwdata[SPEED_W-1:0];
                REG_ANGLE_SLEW: r_angle_slew <= pwdata[ANGLE_W-1:0];
                REG_ALPHA:      r_alpha      <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MOTOR_SLEW: prdata = {17'd0, r_motor_slew};
            REG_ANGLE_SLEW: prdata = {15'd0, r_angle_slew};
            REG_ALPHA:      prdata = {23'd0, r_alpha};
            default:        prdata = '0;
        endcase
    end

    assign w_alpha = r_alpha[8] ? ALPHA_FULL : r_alpha;

    // Pipeline control: each stage moves when the one after it has room.
    assign w_en_out   = !r_out_valid || !i_out_stall;
    assign w_en_mid   = !r_mid_valid || w_en_out;
    assign w_fire     = r_in_valid && w_en_mid;
    assign o_in_stall = r_in_valid && !w_en_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_en_mid) begin
                r_mid_valid <= r_in_valid;
            end
            if (w_en_out) begin
                r_out_valid <= r_mid_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // The state registers are written by the same edge that fills the middle stage and
    // are not written again until it drains, so they carry the middle stage's values.
    mss_motor u_motor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_fire),
        .i_dir       (r_in.target_direction),
        .i_speed     (r_in.target_speed),
        .i_estop     (r_in.drive_halt),
        .i_slew_step (r_motor_slew),
        .o_dir       (w_dir),
        .o_speed     (w_speed)
    );

    assign w_target[0] = r_in.target_shoulder_left;
    assign w_target[1] = r_in.target_shoulder_right;
    assign w_target[2] = r_in.target_elbow_left;
    assign w_target[3] = r_in.target_elbow_right;

    for (genvar g = 0; g < 4; g++) begin : g_joint
        mss_joint u_joint (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_en          (w_fire),
            .i_reset_angle (RESET_ANGLE),
            .i_target      (w_target[g]),
            .i_slew_step   (r_angle_slew),
            .i_alpha       (w_alpha),
            .o_angle       (w_angle[g])
        );
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pulse_prod[k] = {26'd0, w_angle[k]} * {17'd0, PULSE_RECIP};
            w_pulse[k] = PULSE_BASE + {1'b0, w_pulse_prod[k][PULSE_SHIFT+10:PULSE_SHIFT]};
        end

        w_duty_sum = w_speed + 15'd128;

        n_out = '0;
        unique case (w_dir)
            DIR_FORWARD: begin
                n_out.motor_one_mode = MODE_FORWARD;
                n_out.motor_two_mode = MODE_FORWARD;
            end
            DIR_BACKWARD: begin
                n_out.motor_one_mode = MODE_BACKWARD;
                n_out.motor_two_mode = MODE_BACKWARD;
            end
            DIR_LEFT: begin
                n_out.motor_one_mode = MODE_BACKWARD;
                n_out.motor_two_mode = MODE_FORWARD;
            end
            DIR_RIGHT: begin
                n_out.motor_one_mode = MODE_FORWARD;
                n_out.motor_two_mode = MODE_BACKWARD;
            end
            default: begin
                n_out.motor_one_mode = MODE_STOP;
                n_out.motor_two_mode = MODE_STOP;
            end
        endcase
        n_out.motor_duty           = (w_dir == DIR_STOP) ? 7'd0 : w_duty_sum[14:8];
        n_out.shoulder_left_pulse  = w_pulse[0];
        n_out.shoulder_right_pulse = w_pulse[1];
        n_out.elbow_left_pulse     = w_pulse[2];
        n_out.elbow_right_pulse    = w_pulse[3];
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out && r_mid_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_speed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_speed <= SPEED_MAX_Q8)
        else $error("drive speed above full scale");

    a_estop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in.drive_halt |=> w_speed == '0 && w_dir == DIR_STOP)
        else $error("emergency stop did not clear the drive state");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_angle[0] <= ANGLE_MAX_Q8 && w_angle[1] <= ANGLE_MAX_Q8 &&
        w_angle[2] <= ANGLE_MAX_Q8 && w_angle[3] <= ANGLE_MAX_Q8)
        else $error("joint angle out of range");

    a_state_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(w_speed) && $stable(w_dir) && $stable(w_angle[0]))
        else $error("state changed without a tick");
`endif

endmodule

/* tb/motion_slew_smoother_top_tb.sv */
// Self-checking testbench for motion_slew_smoother_top: random and directed control ticks,
// with a per-tick predictor of drive and joint state and a check of every result beat.
// Depends on mss_pkg and the motion_slew_smoother_top RTL.
module motion_slew_smoother_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mss_pkg::*;

    localparam int DEFAULT_DEG   = 90;
    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_LONG     = 200;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REG_UNMAPPED  = 3;
    localparam int PULSE_SPAN_US = 2000;
    localparam int SPEED_CAP     = SPEED_MAX_Q8;
    localparam int ANGLE_CAP     = ANGLE_MAX_Q8;
    localparam int ONE_PCT       = ONE_Q8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    t_in_beat           in_data = '0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_beat          o_out_data;
    logic [31:0]        prdata;
    logic               pready;

    motion_slew_smoother_top #(
        .DEFAULT_ANGLE(DEFAULT_DEG)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted block state and register copies.
    logic [2:0] drive_dir = DIR_STOP;
    int         drive_speed = 0;
    int         joint_q8 [4] = '{default: DEFAULT_DEG * 256};
    int         motor_step_q8 = MOTOR_SLEW_RESET;
    int         angle_step_q8 = ANGLE_SLEW_RESET;
    int         alpha_w = ALPHA_RESET;

    t_in_beat   ticks_pending [$];
    t_out_beat  results_due [$];
    t_out_beat  expected_beat;

    bit         steady = 1'b0;
    bit         hold_req = 1'b0;
    bit         beat_taken = 1'b0;
    bit         result_taken = 1'b0;
    int         in_gap = 0;
    int         out_wait = 0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         errors = 0;
    int         ticks_checked = 0;
    int         estop_ticks = 0;
    int         backpressure_cycles = 0;
    int         settings_used = 1;

    function automatic int step_limit(int cur, int tgt, int step);
        int d;
        if (step <= 0) return tgt;
        d = tgt - cur;
        if (d > step) return cur + step;
        if (d < -step) return cur - step;
        return tgt;
    endfunction

    function automatic int smooth_joint(int cur, int tgt);
        int lim, d, a, r;
        lim = step_limit(cur, tgt, angle_step_q8);
        d = lim - cur;
        a = (alpha_w > int'(ALPHA_FULL)) ? int'(ALPHA_FULL) : alpha_w;
        // The filter step is floored, so negative steps round away from zero.
        if (d >= 0) begin
            r = (a * d) >> 8;
        end else begin
            r = -((a * (-d) + 255) >> 8);
        end
        r += cur;
        if (r < 0) r = 0;
        if (r > ANGLE_CAP) r = ANGLE_CAP;
        return r;
    endfunction

    function automatic logic [PULSE_W-1:0] servo_pulse(int q8);
        return PULSE_W'(int'(PULSE_BASE) + (q8 * PULSE_SPAN_US) / ANGLE_CAP);
    endfunction

    function automatic t_out_beat advance_tick(t_in_beat b);
        t_out_beat  o;
        logic [2:0] want_dir;
        int         want_spd, spd_tgt, t, duty;
        logic [8:0] raw [4];
        o = '0;
        want_dir = (b.target_direction > DIR_RIGHT) ? DIR_STOP : b.target_direction;
        want_spd = (b.target_speed > SPEED_PCT_MAX) ? SPEED_PCT_MAX : b.target_speed;
        if (b.drive_halt) begin
            drive_dir = DIR_STOP;
            drive_speed = 0;
        end else begin
            spd_tgt = (want_dir == DIR_STOP) ? 0 : want_spd * 256;
            // A new direction is only taken once the speed has ramped down to 1 percent.
            if (want_dir != drive_dir && drive_speed > ONE_PCT) begin
                drive_speed = step_limit(drive_speed, 0, motor_step_q8);
                if (drive_speed <= ONE_PCT) begin
                    drive_dir = want_dir;
                    drive_speed = 0;
                end
            end else begin
                drive_dir = want_dir;
                drive_speed = step_limit(drive_speed, spd_tgt, motor_step_q8);
            end
            if (drive_speed < 0) drive_speed = 0;
            if (drive_speed > SPEED_CAP) drive_speed = SPEED_CAP;
            case (drive_dir)
                DIR_FORWARD: begin
                    o.motor_one_mode = MODE_FORWARD;
                    o.motor_two_mode = MODE_FORWARD;
                end
                DIR_BACKWARD: begin
                    o.motor_one_mode = MODE_BACKWARD;
                    o.motor_two_mode = MODE_BACKWARD;
                end
                DIR_LEFT: begin
                    o.motor_one_mode = MODE_BACKWARD;
                    o.motor_two_mode = MODE_FORWARD;
                end
                DIR_RIGHT: begin
                    o.motor_one_mode = MODE_FORWARD;
                    o.motor_two_mode = MODE_BACKWARD;
                end
                default: begin
                    o.motor_one_mode = MODE_STOP;
                    o.motor_two_mode = MODE_STOP;
                end
            endcase
            if (drive_dir != DIR_STOP) begin
                duty = (drive_speed + 128) >> 8;
                if (duty > int'(SPEED_PCT_MAX)) duty = SPEED_PCT_MAX;
                o.motor_duty = 7'(duty);
            end
        end
        raw[0] = b.target_shoulder_left;
        raw[1] = b.target_shoulder_right;
        raw[2] = b.target_elbow_left;
        raw[3] = b.target_elbow_right;
        for (int i = 0; i < 4; i++) begin
            t = raw[i];
            if (t > int'(ANGLE_DEG_MAX)) t = ANGLE_DEG_MAX;
            joint_q8[i] = smooth_joint(joint_q8[i], t * 256);
        end
        o.shoulder_left_pulse  = servo_pulse(joint_q8[0]);
        o.shoulder_right_pulse = servo_pulse(joint_q8[1]);
        o.elbow_left_pulse     = servo_pulse(joint_q8[2]);
        o.elbow_right_pulse    = servo_pulse(joint_q8[3]);
        return o;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Sampling at the rising edge; all inputs change on the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall) begin
            results_due.push_back(advance_tick(in_data));
            if (in_data.drive_halt) estop_ticks++;
            beat_taken = 1'b1;
        end
        if (i_rst_n && in_valid && o_in_stall) backpressure_cycles++;
        if (i_rst_n && o_out_valid && !out_stall) begin
            result_taken = 1'b1;
            if (results_due.size() == 0) begin
                $error("result beat arrived with no control tick outstanding");
                errors++;
            end else begin
                expected_beat = results_due.pop_front();
                check_field("motor_one_mode", expected_beat.motor_one_mode,
                            o_out_data.motor_one_mode);
                check_field("motor_two_mode", expected_beat.motor_two_mode,
                            o_out_data.motor_two_mode);
                check_field("motor_duty", expected_beat.motor_duty, o_out_data.motor_duty);
                check_field("shoulder_left_pulse", expected_beat.shoulder_left_pulse,
                            o_out_data.shoulder_left_pulse);
                check_field("shoulder_right_pulse", expected_beat.shoulder_right_pulse,
                            o_out_data.shoulder_right_pulse);
                check_field("elbow_left_pulse", expected_beat.elbow_left_pulse,
                            o_out_data.elbow_left_pulse);
                check_field("elbow_right_pulse", expected_beat.elbow_right_pulse,
                            o_out_data.elbow_right_pulse);
                ticks_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Tick driver: one beat per pending item, with a drawn gap after each accepted beat.
    always @(negedge i_clk) begin
        if (beat_taken) begin
            beat_taken = 1'b0;
            in_gap = steady ? 0 : $urandom_range(0, 14);
            if (in_gap == 0 && ticks_pending.size() > 0) begin
                in_data <= ticks_pending.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid && i_rst_n) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (ticks_pending.size() > 0) begin
                in_valid <= 1'b1;
                in_data <= ticks_pending.pop_front();
            end
        end
    end

    // Result receiver: a drawn wait after each beat, and one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_LONG;
            hold_req = 1'b0;
        end
        if (result_taken) begin
            result_taken = 1'b0;
            out_wait = steady ? 0 : $urandom_range(0, 14);
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic apb_xfer(bit wr, int idx, logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= PADDR_W'(idx * 4);
        pwdata <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [31:0] m, logic [31:0] a, logic [31:0] al);
        logic [31:0] rd;
        apb_xfer(1'b1, REG_MOTOR_SLEW, m, rd);
        motor_step_q8 = m[14:0];
        apb_xfer(1'b1, REG_ANGLE_SLEW, a, rd);
        angle_step_q8 = a[16:0];
        apb_xfer(1'b1, REG_ALPHA, al, rd);
        alpha_w = al[8:0];
        apb_xfer(1'b0, REG_MOTOR_SLEW, '0, rd);
        check_field("motor_slew_step readback", motor_step_q8, rd);
        apb_xfer(1'b0, REG_ANGLE_SLEW, '0, rd);
        check_field("angle_slew_step readback", angle_step_q8, rd);
        apb_xfer(1'b0, REG_ALPHA, '0, rd);
        check_field("filter_alpha readback", alpha_w, rd);
        settings_used++;
    endtask

    function automatic t_in_beat tick(logic [2:0] dir, logic [6:0] spd, logic [8:0] sl,
                                      logic [8:0] sr, logic [8:0] el, logic [8:0] er,
                                      logic es);
        t_in_beat b;
        b.target_direction      = dir;
        b.target_speed          = spd;
        b.target_shoulder_left  = sl;
        b.target_shoulder_right = sr;
        b.target_elbow_left     = el;
        b.target_elbow_right    = er;
        b.drive_halt            = es;
        return b;
    endfunction

    function automatic logic [8:0] pick_angle();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ANGLE_DEG_MAX;
            2: return 9'($urandom_range(271, 511));
            default: return 9'($urandom_range(0, 270));
        endcase
    endfunction

    // Mostly held commands with random content, so the drive ramps and direction
    // handovers play out; the rest is raw noise across every field bit.
    task automatic queue_random(int n);
        int         run_left;
        logic [2:0] run_dir;
        logic [6:0] run_speed;
        logic [8:0] run_ang [4];
        logic [63:0] noise;
        run_left = 0;
        for (int k = 0; k < n; k++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(1, 12);
                run_dir = ($urandom_range(0, 9) == 0) ? 3'(DIR_RIGHT + $urandom_range(1, 3))
                                                      : 3'($urandom_range(0, 4));
                run_speed = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(101, 127))
                                                        : 7'($urandom_range(0, 100));
                for (int i = 0; i < 4; i++) run_ang[i] = pick_angle();
            end
            run_left--;
            if ($urandom_range(0, 99) < 12) begin
                noise = {$urandom, $urandom};
                ticks_pending.push_back(noise[$bits(t_in_beat)-1:0]);
            end else begin
                ticks_pending.push_back(tick(run_dir, run_speed, run_ang[0], run_ang[1],
                                             run_ang[2], run_ang[3],
                                             $urandom_range(0, 99) < 3));
            end
        end
    endtask

    task automatic wait_idle();
        while (ticks_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [31:0] rd;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: ramp up, direction change while moving, out-of-range codes,
        // saturation, emergency stop, stop with a speed request, and a small angle step.
        repeat (5) ticks_pending.push_back(tick(DIR_FORWARD, 100, 0, 270, 90, 270, 0));
        repeat (4) ticks_pending.push_back(tick(DIR_BACKWARD, 100, 271, 511, 0, 0, 0));
        for (int k = 1; k <= 3; k++)
            ticks_pending.push_back(tick(3'(DIR_RIGHT + k), 60, 511, 0, 271, 135, 0));
        ticks_pending.push_back(tick(DIR_BACKWARD, 100, 270, 270, 270, 270, 0));
        repeat (3) ticks_pending.push_back(tick(DIR_LEFT, 127, 511, 511, 511, 511, 0));
        ticks_pending.push_back(tick(DIR_RIGHT, 100, 0, 0, 0, 0, 1));
        repeat (2) ticks_pending.push_back(tick(DIR_RIGHT, 100, 0, 0, 0, 0, 0));
        repeat (2) ticks_pending.push_back(tick(DIR_STOP, 100, 90, 90, 90, 90, 0));
        repeat (2) ticks_pending.push_back(tick(DIR_FORWARD, 0, 91, 91, 91, 91, 0));
        wait_idle();

        // An unmapped address must leave the register file alone.
        apb_xfer(1'b1, REG_UNMAPPED, $urandom, rd);
        configure(0, 0, ALPHA_FULL);
        queue_random(140);
        wait_idle();

        // Full-size steps with a frozen filter; the receiver holds off long enough
        // for the pipeline to fill and stall the tick input.
        configure(SPEED_MAX_Q8, ANGLE_MAX_Q8, 0);
        steady = 1'b1;
        queue_random(140);
        hold_req = 1'b1;
        wait_idle();
        steady = 1'b0;

        configure(32'h7FFF, 32'h1FFFF, 32'h1FF);
        queue_random(140);
        wait_idle();

        configure(1, 1, 1);
        queue_random(140);
        wait_idle();

        configure(MOTOR_SLEW_RESET, ANGLE_SLEW_RESET, ALPHA_RESET);
        queue_random(140);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            configure($urandom_range(0, 25600), $urandom_range(0, 69120),
                      $urandom_range(0, 256));
            steady = ($urandom_range(0, 2) == 0);
            queue_random(140);
            wait_idle();
            steady = 1'b0;
        end

        if (results_due.size() != 0) begin
            $error("%0d expected results never arrived", results_due.size());
            errors++;
        end
        $display("Checked %0d control ticks (%0d with emergency stop) over %0d register settings.",
                 ticks_checked, estop_ticks, settings_used);
        $display("Tick input was held back for %0d cycles by output back-pressure.",
                 backpressure_cycles);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/mss_pkg.sv
hdl/mss_motor.sv
hdl/mss_joint.sv
hdl/motion_slew_smoother_top.sv
tb/motion_slew_smoother_top_tb.sv
